[design/sch_pkg.sv]
// Package for the sparse cumulative height index core.
// Holds sizes, request and status codes, and controller/datapath link types.
// No dependencies.
package sch_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_TRUNC = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [31:0] height;
        logic [62:0] amt;
        logic [63:0] intr;
    } entry_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic decide;
        logic srch_rd;
        logic srch_step;
        logic trunc_commit;
        logic load_rd;
        logic load_cap;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       pop_empty;
        logic       trunc_hit;
        logic       query_empty;
        logic       srch_done;
        logic       out_free;
    } sts_t;

endpackage

[design/sch_if.sv]
// Handshake channel interfaces for requests and results.
// Depends on nothing beyond the package ordering.
interface sch_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [63:0] amount_delta;
    logic [63:0]        interest_delta;
    logic [31:0]        height;
    modport source (output valid, req_type, amount_delta, interest_delta, height,
                    input ready);
    modport sink (input valid, req_type, amount_delta, interest_delta, height,
                  output ready);
endinterface

interface sch_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [62:0] amount_total;
    logic [63:0] interest_total;
    logic [31:0] block_count;
    logic [31:0] removed_count;
    modport source (output valid, status, amount_total, interest_total, block_count,
                    removed_count, input ready);
    modport sink (input valid, status, amount_total, interest_total, block_count,
                  removed_count, output ready);
endinterface

[design/sch_ctrl.sv]
// Controller state machine for the height index core.
// Depends on sch_pkg for the command and status types.
module sch_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sch_pkg::sts_t sts,
    output sch_pkg::cmd_t cmd
);
    import sch_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_SRCH     = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_LOAD     = 3'd4;
    localparam logic [2:0] S_LOAD_CAP = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                case (sts.req_type)
                    REQ_PUSH:  state_next = S_FINISH;
                    REQ_POP:   state_next = sts.pop_empty ? S_FINISH : S_LOAD;
                    REQ_TRUNC: state_next = sts.trunc_hit ? S_SRCH : S_FINISH;
                    REQ_QUERY: state_next = sts.query_empty ? S_FINISH : S_SRCH;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_SRCH:
            begin
                if (sts.srch_done)
                begin
                    cmd.trunc_commit = (sts.req_type == REQ_TRUNC);
                    state_next       = S_LOAD;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH;
            end
            S_LOAD:
            begin
                cmd.load_rd = 1'b1;
                state_next  = S_LOAD_CAP;
            end
            S_LOAD_CAP:
            begin
                cmd.load_cap = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/sch_dp.sv]
// Datapath for the height index core: entry memory, counters, search window
// and result registers. Depends on sch_pkg.
module sch_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  sch_pkg::cmd_t      cmd,
    output sch_pkg::sts_t      sts,
    input  logic [1:0]         req_type,
    input  logic signed [63:0] amount_delta,
    input  logic [63:0]        interest_delta,
    input  logic [31:0]        height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [62:0]        amount_total,
    output logic [63:0]        interest_total,
    output logic [31:0]        block_count,
    output logic [31:0]        removed_count
);
    import sch_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_reg;

    logic [1:0]  type_reg;
    logic [63:0] delta_reg;
    logic [63:0] idelta_reg;
    logic [31:0] h_reg;

    logic [CNT_W-1:0] ec_reg;
    logic [31:0]      bc_reg;
    entry_t           tail_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg;
    logic [1:0]       st_reg;
    logic [31:0]      removed_reg;
    logic [62:0]      q_amt_reg;
    logic [63:0]      q_int_reg;

    logic             out_valid_reg;
    logic [1:0]       o_st_reg;
    logic [62:0]      o_amt_reg;
    logic [63:0]      o_int_reg;
    logic [31:0]      o_bc_reg;
    logic [31:0]      o_rm_reg;

    // push arithmetic on the tail totals
    logic [64:0]      amt_sum;
    logic [64:0]      int_sum;
    logic             push_bad, push_full, delta_nz;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] load_idx;
    logic [IDX_W-1:0] load_addr;
    logic             go_right;
    logic [31:0]      bc_dec;

    assign amt_sum   = {2'b00, tail_reg.amt} + {delta_reg[63], delta_reg};
    assign int_sum   = {1'b0, tail_reg.intr} + {1'b0, idelta_reg};
    assign push_bad  = amt_sum[64] | amt_sum[63] | int_sum[64];
    assign delta_nz  = (delta_reg != 64'd0);
    assign push_full = (bc_reg == 32'hFFFF_FFFF) ||
                       (delta_nz && (ec_reg == CNT_W'(ENTRIES)));
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right  = (type_reg == REQ_QUERY) ? (rd_reg.height <= h_reg)
                                               : (rd_reg.height < h_reg);
    assign load_idx  = (type_reg == REQ_QUERY) ? lo_reg : ec_reg;
    assign load_addr = IDX_W'(load_idx - CNT_W'(1));
    assign bc_dec    = bc_reg - 32'd1;

    assign sts.req_type    = type_reg;
    assign sts.pop_empty   = (bc_reg == 32'd0);
    assign sts.trunc_hit   = (h_reg < bc_reg);
    assign sts.query_empty = (bc_reg == 32'd0);
    assign sts.srch_done   = (lo_reg >= hi_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.decide && (type_reg == REQ_PUSH) && !push_bad && !push_full && delta_nz)
        begin
            mem[ec_reg[IDX_W-1:0]] <= '{height: bc_reg, amt: amt_sum[62:0],
                                        intr: int_sum[63:0]};
        end
        if (cmd.srch_rd)
        begin
            rd_reg <= mem[mid[IDX_W-1:0]];
        end
        else if (cmd.load_rd)
        begin
            rd_reg <= mem[load_addr];
        end
    end

    // request capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            type_reg   <= req_type;
            delta_reg  <= amount_delta;
            idelta_reg <= interest_delta;
            h_reg      <= height;
        end
        if (cmd.decide)
        begin
            lo_reg      <= '0;
            hi_reg      <= ec_reg;
            removed_reg <= 32'd0;
            q_amt_reg   <= '0;
            q_int_reg   <= '0;
            case (type_reg)
                REQ_PUSH: st_reg <= push_bad ? ST_SUM : (push_full ? ST_FULL : ST_OK);
                REQ_POP:  st_reg <= (bc_reg == 32'd0) ? ST_EMPTY : ST_OK;
                default:  st_reg <= ST_OK;
            endcase
        end
        if (cmd.srch_step)
        begin
            if (go_right)
            begin
                lo_reg <= mid + CNT_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.trunc_commit)
        begin
            removed_reg <= bc_reg - h_reg;
        end
        if (cmd.load_cap && (type_reg == REQ_QUERY) && (lo_reg != '0))
        begin
            q_amt_reg <= rd_reg.amt;
            q_int_reg <= rd_reg.intr;
        end
    end

    // index state: counters and cached last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_reg   <= '0;
            bc_reg   <= 32'd0;
            tail_reg <= '0;
        end
        else
        begin
            if (cmd.decide && (type_reg == REQ_PUSH) && !push_bad && !push_full)
            begin
                bc_reg <= bc_reg + 32'd1;
                if (delta_nz)
                begin
                    ec_reg   <= ec_reg + CNT_W'(1);
                    tail_reg <= '{height: bc_reg, amt: amt_sum[62:0], intr: int_sum[63:0]};
                end
            end
            if (cmd.decide && (type_reg == REQ_POP) && (bc_reg != 32'd0))
            begin
                bc_reg <= bc_dec;
                if ((ec_reg != '0) && (tail_reg.height == bc_dec))
                begin
                    ec_reg <= ec_reg - CNT_W'(1);
                end
            end
            if (cmd.trunc_commit)
            begin
                ec_reg <= lo_reg;
                bc_reg <= h_reg;
            end
            if (cmd.load_cap && (type_reg != REQ_QUERY))
            begin
                tail_reg <= (ec_reg != '0) ? rd_reg : '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_st_reg  <= st_reg;
            o_amt_reg <= (type_reg == REQ_QUERY) ? q_amt_reg : tail_reg.amt;
            o_int_reg <= (type_reg == REQ_QUERY) ? q_int_reg : tail_reg.intr;
            o_bc_reg  <= bc_reg;
            o_rm_reg  <= removed_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_st_reg;
    assign amount_total   = o_amt_reg;
    assign interest_total = o_int_reg;
    assign block_count    = o_bc_reg;
    assign removed_count  = o_rm_reg;

    // entry count never passes the table size
    a_ec_range: assert property (@(posedge clk) disable iff (!rst_n)
        ec_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // cached last entry lies below the block count between requests
    a_tail_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && (ec_reg != '0) |-> tail_reg.height < bc_reg)
        else $error("last entry height not below block count");

    // an accepted nonzero push adds one entry
    a_push_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && (type_reg == REQ_PUSH) && !push_bad && !push_full && delta_nz
        |=> ec_reg == $past(ec_reg) + CNT_W'(1))
        else $error("push did not add an entry");

    // a search step always has a nonempty window
    a_srch_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |-> hi_reg > lo_reg)
        else $error("search step on empty window");

endmodule

[design/sparse_cumulative_height_index_core.sv]
// Top level of the sparse cumulative height index core.
// Depends on sch_pkg, sch_if, sch_ctrl and sch_dp.
//
// One request is worked at a time; the result sits in an output register so
// the next request can be taken while it waits. Push goes straight to the
// result load; a pop that finds blocks first reads and captures the new
// last entry; a truncate that hits and a nonempty query run a binary search
// over the live entries (at most 11 steps for 1024 entries), then a read
// and capture. Each search step is one read and one compare on the entry
// memory with registered read. No clearing pass is needed after reset.
module sparse_cumulative_height_index_core (
    input logic      clk,
    input logic      rst_n,
    sch_req_if.sink  req,
    sch_rsp_if.source rsp
);
    import sch_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    sch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    sch_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req.req_type),
        .amount_delta   (req.amount_delta),
        .interest_delta (req.interest_delta),
        .height         (req.height),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .status         (rsp.status),
        .amount_total   (rsp.amount_total),
        .interest_total (rsp.interest_total),
        .block_count    (rsp.block_count),
        .removed_count  (rsp.removed_count)
    );

endmodule
